// ===== sv/ethm_pkg.sv =====
// Shared payload types and fixed-point constants for the escape-time colour mapper.
package ethm_pkg;

  typedef struct packed {
    logic [15:0] iter_count;
    logic [31:0] escape_magnitude_sq;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       is_interior;
  } out_t;

  // Configuration register indexes (word address bit 2).
  localparam logic REG_COLOUR_MODE = 1'b0;
  localparam logic REG_ITER_LIMIT  = 1'b1;

  localparam logic [15:0] LIMIT_RESET = 16'd256;

  // Hue in degrees with 16 fraction bits.
  localparam int          QW       = 25;
  localparam int          DEN_W    = 16;
  localparam int          DIV_W    = DEN_W + QW;
  localparam logic [24:0] DEG60    = 25'd3932160;
  localparam logic [24:0] TWO60    = 25'd7864320;
  localparam logic [24:0] FIVE60   = 25'd19660800;
  localparam logic [24:0] HUE_FULL = 25'd23592960;
  localparam logic [24:0] DEG_SPAN = 25'd360;

  // 1.5288 in Q16.
  localparam logic [34:0] NU_OFFSET = 35'd100191;

  // floor(v / 300) = (v * RECIP_K) >> RECIP_SHIFT for v below 76501.
  localparam logic [16:0] RECIP_K     = 17'd111849;
  localparam int          RECIP_SHIFT = 25;

  localparam logic [7:0] CHAN_FULL = 8'd255;
  localparam logic [7:0] CHAN_NONE = 8'd51;

  // Edges from an accepted start to the strobe being seen.
  localparam int LATENCY = 65;

endpackage

// ===== sv/ethm_log2.sv =====
// Pipelined log2 with 16 fraction bits: normalize, then one squaring per stage.
module ethm_log2 #(
  parameter int FRAC   = 16,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [31:0]              x,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_valid,
  output logic signed [23:0]       lg,
  output logic [SIDE_W-1:0]        out_side
);

  localparam int STEPS = 16;

  logic [4:0]               msb;
  logic                     vld  [0:STEPS];
  logic [31:0]              y    [0:STEPS];
  logic signed [23:0]       acc  [0:STEPS];
  logic [SIDE_W-1:0]        sd   [0:STEPS];
  logic [63:0]              prod [0:STEPS-1];
  logic [32:0]              sq   [0:STEPS-1];

  always_comb begin
    msb = '0;
    for (int b = 1; b < 32; b++) begin
      if (x[b]) msb = 5'(b);
    end
  end

  always_comb begin
    for (int i = 0; i < STEPS; i++) begin
      prod[i] = 64'(y[i]) * 64'(y[i]);
      sq[i]   = prod[i][63:31];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= STEPS; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int i = 0; i < STEPS; i++) vld[i+1] <= vld[i];
    end
    y[0]   <= x << (5'd31 - msb);
    acc[0] <= {8'(msb) - 8'(FRAC), 16'h0000};
    sd[0]  <= in_side;
    for (int i = 0; i < STEPS; i++) begin
      // renormalize to [1,2) and emit one fraction bit
      y[i+1]   <= sq[i][32] ? sq[i][32:1] : sq[i][31:0];
      acc[i+1] <= sq[i][32] ? (acc[i] | (24'd1 << (STEPS - 1 - i))) : acc[i];
      sd[i+1]  <= sd[i];
    end
  end

  assign out_valid = vld[STEPS];
  assign lg        = acc[STEPS];
  assign out_side  = sd[STEPS];

endmodule

// ===== sv/ethm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module ethm_div #(
  parameter int SIDE_W = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [ethm_pkg::DIV_W-1:0] dividend,
  input  logic [ethm_pkg::DEN_W-1:0] divisor,
  input  logic [SIDE_W-1:0]         in_side,
  output logic                      out_valid,
  output logic [ethm_pkg::QW-1:0]   quotient,
  output logic [SIDE_W-1:0]         out_side
);

  localparam int QW = ethm_pkg::QW;
  localparam int DW = ethm_pkg::DEN_W;

  logic              vld [0:QW];
  logic [DW-1:0]     rem [0:QW];
  logic [QW-1:0]     w   [0:QW];
  logic [DW-1:0]     dv  [0:QW];
  logic [SIDE_W-1:0] sd  [0:QW];
  logic [DW:0]       tr  [0:QW-1];
  logic [DW:0]       df  [0:QW-1];
  logic              ge  [0:QW-1];

  always_comb begin
    for (int i = 0; i < QW; i++) begin
      tr[i] = {rem[i], w[i][QW-1]};
      ge[i] = tr[i] >= {1'b0, dv[i]};
      df[i] = tr[i] - {1'b0, dv[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= QW; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int i = 0; i < QW; i++) vld[i+1] <= vld[i];
    end
    rem[0] <= dividend[ethm_pkg::DIV_W-1:QW];
    w[0]   <= dividend[QW-1:0];
    dv[0]  <= divisor;
    sd[0]  <= in_side;
    for (int i = 0; i < QW; i++) begin
      // shift a dividend bit in, a quotient bit out
      rem[i+1] <= ge[i] ? df[i][DW-1:0] : tr[i][DW-1:0];
      w[i+1]   <= {w[i][QW-2:0], ge[i]};
      dv[i+1]  <= dv[i];
      sd[i+1]  <= sd[i];
    end
  end

  assign out_valid = vld[QW];
  assign quotient  = w[QW];
  assign out_side  = sd[QW];

endmodule

// ===== sv/escape_time_hsv_colour_mapper.sv =====
// Top level: escape count to RGB colour, fully pipelined, with APB register port.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------
//  input    | start, busy            | item   (ethm_pkg::in_t)
//  result   | strobe                 | result (ethm_pkg::out_t)
//  config   | psel, penable, pwrite  | paddr, pwdata, prdata
//
// One pixel enters per cycle while busy is low; it passes through two 17-stage log2
// pipes (normalize, then one squaring per stage) and a 26-stage divider.
// busy is high during reset and for the cycle after it; otherwise start is always taken.
// Reset clears all valid bits and sets the registers to linear mode, limit 256.
// There is no stall: each result is shown for exactly one cycle.
module escape_time_hsv_colour_mapper #(
  parameter int ITER_BITS     = 16,
  parameter int MAG_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  ethm_pkg::in_t        item,
  output logic                 strobe,
  output ethm_pkg::out_t       result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int          IW        = (ITER_BITS < 16) ? ITER_BITS : 16;
  localparam logic [15:0] ITER_MASK = 16'((64'd1 << IW) - 64'd1);

  typedef enum logic [2:0] {
    SEC_RY, SEC_YG, SEC_GC, SEC_CB, SEC_BM, SEC_MR, SEC_WRAP
  } sector_t;

  // configuration
  logic        colour_mode;
  logic [15:0] iteration_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      colour_mode     <= 1'b0;
      iteration_limit <= ethm_pkg::LIMIT_RESET;
      busy            <= 1'b1;
    end else begin
      busy <= 1'b0;
      if (psel && penable && pwrite) begin
        case (paddr[2])
          ethm_pkg::REG_COLOUR_MODE: colour_mode     <= pwdata[0];
          ethm_pkg::REG_ITER_LIMIT:  iteration_limit <= pwdata[15:0] & ITER_MASK;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (paddr[2])
      ethm_pkg::REG_COLOUR_MODE: prdata = {31'h0, colour_mode};
      ethm_pkg::REG_ITER_LIMIT:  prdata = {16'h0, iteration_limit};
      default:                   prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // first log2 of the magnitude
  logic        in_valid;
  logic [15:0] iter_m;
  logic        mag_small;
  assign in_valid  = start && !busy;
  assign iter_m    = item.iter_count & ITER_MASK;
  assign mag_small = {1'b0, item.escape_magnitude_sq} <= (33'd1 << MAG_FRAC_BITS);

  logic               la_valid;
  logic signed [23:0] la_lg;
  logic [16:0]        la_side;

  ethm_log2 #(.FRAC(MAG_FRAC_BITS), .SIDE_W(17)) u_log_mag (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .x        (item.escape_magnitude_sq),
    .in_side  ({iter_m, mag_small}),
    .out_valid(la_valid),
    .lg       (la_lg),
    .out_side (la_side)
  );

  // second log2 of the first one
  logic               leq0;
  logic               lb_valid;
  logic signed [23:0] lb_lg;
  logic [17:0]        lb_side;
  assign leq0 = la_lg <= 24'sd0;

  ethm_log2 #(.FRAC(16), .SIDE_W(18)) u_log_log (
    .clk      (clk),
    .rst      (rst),
    .in_valid (la_valid),
    .x        ({8'h00, la_lg}),
    .in_side  ({la_side, leq0}),
    .out_valid(lb_valid),
    .lg       (lb_lg),
    .out_side (lb_side)
  );

  // smooth count numerator t * 2^16
  logic signed [34:0] top35;
  logic signed [34:0] base35;
  logic signed [34:0] nu35;
  logic [16:0]        iter_p1;
  assign top35   = signed'({3'b000, iteration_limit, 16'h0000});
  assign iter_p1 = 17'(lb_side[17:2]) + 17'd1;
  assign base35  = signed'({2'b00, iter_p1, 16'h0000});
  assign nu35    = 35'(lb_lg) - signed'(ethm_pkg::NU_OFFSET);

  logic               t1_valid;
  logic [15:0]        t1_iter;
  logic               t1_small;
  logic signed [34:0] t1_tnum;

  always_ff @(posedge clk) begin
    if (rst) t1_valid <= 1'b0;
    else     t1_valid <= lb_valid;
    t1_iter  <= lb_side[17:2];
    t1_small <= lb_side[1];
    t1_tnum  <= lb_side[0] ? top35 : base35 - nu35;
  end

  // pick the divide or a fixed hue
  logic                       interior;
  logic                       byp;
  logic                       full;
  logic [24:0]                lin_prod;
  logic [ethm_pkg::DIV_W-1:0] num;

  assign interior = t1_iter >= iteration_limit;
  assign lin_prod = 25'(t1_iter) * ethm_pkg::DEG_SPAN;

  always_comb begin
    byp  = 1'b0;
    full = 1'b0;
    num  = {lin_prod, 16'h0000};
    if (colour_mode) begin
      num = 41'(t1_tnum[31:0]) * 41'(ethm_pkg::DEG_SPAN);
      if (t1_small || t1_tnum <= 35'sd0) begin
        byp = 1'b1;
      end else if (t1_tnum >= top35) begin
        byp  = 1'b1;
        full = 1'b1;
      end
    end
    if (interior) byp = 1'b1;
    if (byp) num = '0;
  end

  logic              dq_valid;
  logic [24:0]       dq;
  logic [2:0]        dq_side;

  ethm_div #(.SIDE_W(3)) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (t1_valid),
    .dividend (num),
    .divisor  (iteration_limit),
    .in_side  ({interior, byp, full}),
    .out_valid(dq_valid),
    .quotient (dq),
    .out_side (dq_side)
  );

  // hue to sector and secondary level
  logic [24:0] hue;
  logic [2:0]  cnt;
  logic [24:0] hbase;
  logic [24:0] hrem;
  logic [24:0] hdist;

  always_comb begin
    if (dq_side[1]) hue = dq_side[0] ? ethm_pkg::HUE_FULL : 25'd0;
    else            hue = dq;
    cnt = '0;
    for (int k = 1; k <= 6; k++) begin
      cnt = cnt + 3'(hue >= 25'(k) * ethm_pkg::DEG60);
    end
    hbase = 25'(cnt[2:1]) * ethm_pkg::TWO60;
    hrem  = hue - hbase;
    hdist = (hrem >= ethm_pkg::DEG60) ? hrem - ethm_pkg::DEG60 : ethm_pkg::DEG60 - hrem;
  end

  logic        c1_valid;
  logic        c1_int;
  sector_t     c1_sec;
  logic [24:0] c1_v;
  logic        c2_valid;
  logic        c2_int;
  sector_t     c2_sec;
  logic [16:0] c2_xs;
  logic        c3_valid;
  logic        c3_int;
  sector_t     c3_sec;
  logic [7:0]  c3_part;
  logic [32:0] x255;
  logic [33:0] rprod;

  assign x255  = 33'(c1_v) * 33'd255;
  assign rprod = 34'(c2_xs) * 34'(ethm_pkg::RECIP_K);

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
      c2_valid <= 1'b0;
      c3_valid <= 1'b0;
    end else begin
      c1_valid <= dq_valid;
      c2_valid <= c1_valid;
      c3_valid <= c2_valid;
    end
    c1_int  <= dq_side[2];
    c1_sec  <= sector_t'(cnt);
    c1_v    <= ethm_pkg::FIVE60 - {hdist[22:0], 2'b00};
    c2_int  <= c1_int;
    c2_sec  <= c1_sec;
    c2_xs   <= x255[32:16];
    c3_int  <= c2_int;
    c3_sec  <= c2_sec;
    c3_part <= rprod[ethm_pkg::RECIP_SHIFT+7:ethm_pkg::RECIP_SHIFT];
  end

  // place the channels
  ethm_pkg::out_t rgb;

  always_comb begin
    rgb.red         = ethm_pkg::CHAN_NONE;
    rgb.green       = ethm_pkg::CHAN_NONE;
    rgb.blue        = ethm_pkg::CHAN_NONE;
    rgb.is_interior = 1'b0;
    case (c3_sec)
      SEC_RY: begin rgb.red   = ethm_pkg::CHAN_FULL; rgb.green = c3_part; end
      SEC_YG: begin rgb.red   = c3_part; rgb.green = ethm_pkg::CHAN_FULL; end
      SEC_GC: begin rgb.green = ethm_pkg::CHAN_FULL; rgb.blue = c3_part; end
      SEC_CB: begin rgb.green = c3_part; rgb.blue = ethm_pkg::CHAN_FULL; end
      SEC_BM: begin rgb.red   = c3_part; rgb.blue = ethm_pkg::CHAN_FULL; end
      default: begin rgb.red  = ethm_pkg::CHAN_FULL; rgb.blue = c3_part; end
    endcase
    if (c3_int) begin
      rgb.red         = 8'd0;
      rgb.green       = 8'd0;
      rgb.blue        = 8'd0;
      rgb.is_interior = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else     strobe <= c3_valid;
    result <= rgb;
  end

endmodule

// ===== sv/ethm_checker.sv =====
// Port-level checks for the colour mapper, bound to the top level.
module ethm_port_checks (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           strobe,
  input ethm_pkg::out_t result,
  input logic           pready
);

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##65 strobe)
    else $error("accepted beat gave no result at fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start && !busy, 65))
    else $error("result beat without a matching accepted beat");

  a_interior_black: assert property (@(posedge clk) disable iff (rst)
    strobe && result.is_interior |->
      result.red == 8'd0 && result.green == 8'd0 && result.blue == 8'd0)
    else $error("interior pixel not black");

  a_floor_level: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.is_interior |->
      result.red >= ethm_pkg::CHAN_NONE && result.green >= ethm_pkg::CHAN_NONE &&
      result.blue >= ethm_pkg::CHAN_NONE)
    else $error("channel below the desaturation floor");

  a_ready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind escape_time_hsv_colour_mapper ethm_port_checks u_ethm_port_checks (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .strobe(strobe),
  .result(result),
  .pready(pready)
);
